[sv/dasd_pkg.sv]
// Shared types, constants and calendar functions for the date add/subtract block.
// Used by dasd_mod400, dasd_core and date_add_subtract_days; depends on nothing.
package dasd_pkg;

   localparam int YEAR_BITS          = 14;
   localparam int MONTH_BITS         = 4;
   localparam int DAY_BITS           = 5;
   localparam int DOY_BITS           = 9;
   localparam int COUNT_PORT_BITS    = 16;
   localparam int DAY_ACC_BITS       = COUNT_PORT_BITS + 7;
   localparam int MOD_BITS           = 9;

   localparam int DEFAULT_MAX_YEAR   = 9999;
   localparam int DEFAULT_COUNT_BITS = 16;
   localparam logic [YEAR_BITS-1:0] BASE_YEAR_RESET = YEAR_BITS'(1900);

   localparam logic [MOD_BITS-1:0] LEAP_CYCLE   = MOD_BITS'(400);
   localparam logic [MOD_BITS-1:0] CENTURY_1    = MOD_BITS'(100);
   localparam logic [MOD_BITS-1:0] CENTURY_2    = MOD_BITS'(200);
   localparam logic [MOD_BITS-1:0] CENTURY_3    = MOD_BITS'(300);
   localparam logic [MOD_BITS-1:0] CYCLE_LAST   = MOD_BITS'(399);

   localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);
   localparam logic [DAY_BITS-1:0]   FEB_LEAP_DAYS = DAY_BITS'(29);
   localparam logic [DAY_BITS-1:0]   DEC_DAYS      = DAY_BITS'(31);
   localparam logic [DAY_BITS-1:0]   FIRST_DAY     = DAY_BITS'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  year;
      logic [MONTH_BITS-1:0] month;
      logic [DAY_BITS-1:0]   day;
      logic [DOY_BITS-1:0]   day_of_year;
      logic                  input_valid;
      logic                  range_error;
   } rsp_type;

   // Leap rule applied to the year reduced modulo 400.
   function automatic logic is_leap(input logic [MOD_BITS-1:0] r);
      return ((r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) &&
              (r != CENTURY_3));
   endfunction

   function automatic logic [DAY_BITS-1:0] days_in_month(input logic [MONTH_BITS-1:0] m,
                                                         input logic leap);
      logic [DAY_BITS-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_BITS'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_BITS'(30);
         4'd2:    len = leap ? FEB_LEAP_DAYS : DAY_BITS'(28);
         default: len = '0;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_BITS-1:0] days_before(input logic [MONTH_BITS-1:0] m,
                                                       input logic leap);
      logic [DOY_BITS-1:0] base;
      case (m)
         4'd2:    base = DOY_BITS'(31);
         4'd3:    base = DOY_BITS'(59);
         4'd4:    base = DOY_BITS'(90);
         4'd5:    base = DOY_BITS'(120);
         4'd6:    base = DOY_BITS'(151);
         4'd7:    base = DOY_BITS'(181);
         4'd8:    base = DOY_BITS'(212);
         4'd9:    base = DOY_BITS'(243);
         4'd10:   base = DOY_BITS'(273);
         4'd11:   base = DOY_BITS'(304);
         4'd12:   base = DOY_BITS'(334);
         default: base = '0;
      endcase
      if (leap && (m > MONTH_FEB) && (m <= MONTH_DEC)) begin
         base = base + DOY_BITS'(1);
      end
      return base;
   endfunction

endpackage

[sv/date_add_subtract_days.sv]
// Top level of the Gregorian date add/subtract block: configuration register and core.
// Depends on dasd_pkg and instantiates dasd_core.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// result has been formed. The block first reduces the year modulo 400 (one step per cycle,
// six steps for the default year range), then checks the date and, for a valid date, walks the
// shifted date one month per cycle through a single add-and-compare unit, and last forms
// the day of year. The result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, and the receiver cannot stall it. The base year register is to be written
// through the csr_ channel only while the block is idle; the block does not enforce this.
module date_add_subtract_days #(
   parameter int MAX_YEAR   = dasd_pkg::DEFAULT_MAX_YEAR,
   parameter int COUNT_BITS = dasd_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [dasd_pkg::YEAR_BITS-1:0]       req_year,
   input  logic [dasd_pkg::MONTH_BITS-1:0]      req_month,
   input  logic [dasd_pkg::DAY_BITS-1:0]        req_day,
   input  logic [dasd_pkg::COUNT_PORT_BITS-1:0] req_day_count,
   output logic                                 rsp_valid,
   output logic [dasd_pkg::YEAR_BITS-1:0]       rsp_out_year,
   output logic [dasd_pkg::MONTH_BITS-1:0]      rsp_out_month,
   output logic [dasd_pkg::DAY_BITS-1:0]        rsp_out_day,
   output logic [dasd_pkg::DOY_BITS-1:0]        rsp_out_day_of_year,
   output logic                                 rsp_input_valid,
   output logic                                 rsp_range_error,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dasd_pkg::YEAR_BITS-1:0]       csr_base_year
);
   import dasd_pkg::*;

   localparam int YEAR_W = ($clog2(MAX_YEAR + 1) > YEAR_BITS) ?
                           $clog2(MAX_YEAR + 1) : YEAR_BITS;

   logic [YEAR_BITS-1:0] base_year_ff, base_year_in;
   rsp_type              rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      base_year_in = base_year_ff;
      if (csr_valid && csr_ready) begin
         base_year_in = csr_base_year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_year_ff <= BASE_YEAR_RESET;
      end else begin
         base_year_ff <= base_year_in;
      end
   end

   dasd_core #(
      .MAX_YEAR  (MAX_YEAR),
      .COUNT_BITS(COUNT_BITS),
      .YEAR_W    (YEAR_W)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .func     (req_func),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .day_count(req_day_count),
      .base_year(base_year_ff),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   assign rsp_out_year        = rsp.year;
   assign rsp_out_month       = rsp.month;
   assign rsp_out_day         = rsp.day;
   assign rsp_out_day_of_year = rsp.day_of_year;
   assign rsp_input_valid     = rsp.input_valid;
   assign rsp_range_error     = rsp.range_error;

endmodule

[sv/dasd_mod400.sv]
// Iterative reduction of a year modulo 400, one conditional subtraction per cycle.
// Depends on dasd_pkg.
module dasd_mod400 #(
   parameter int YEAR_W = dasd_pkg::YEAR_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [YEAR_W-1:0]             year,
   output logic                          done,
   output logic [dasd_pkg::MOD_BITS-1:0] rem
);
   import dasd_pkg::*;

   localparam int STEPS  = YEAR_W - 8;
   localparam int STEP_W = $clog2(STEPS);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [YEAR_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [YEAR_W:0]   divisor;

   always_comb begin
      divisor = (YEAR_W + 1)'(LEAP_CYCLE) << step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (start) begin
         run_in  = 1'b1;
         rem_in  = year;
         step_in = STEP_W'(STEPS - 1);
      end else if (run_ff) begin
         if ({1'b0, rem_ff} >= divisor) begin
            rem_in = rem_ff - divisor[YEAR_W-1:0];
         end
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[MOD_BITS-1:0];

endmodule

[sv/dasd_core.sv]
// Sequencer and month stepping datapath of the date add/subtract block.
// Depends on dasd_pkg and instantiates dasd_mod400.
module dasd_core #(
   parameter int MAX_YEAR   = dasd_pkg::DEFAULT_MAX_YEAR,
   parameter int COUNT_BITS = dasd_pkg::DEFAULT_COUNT_BITS,
   parameter int YEAR_W     = dasd_pkg::YEAR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 func,
   input  logic [dasd_pkg::YEAR_BITS-1:0]       year,
   input  logic [dasd_pkg::MONTH_BITS-1:0]      month,
   input  logic [dasd_pkg::DAY_BITS-1:0]        day,
   input  logic [dasd_pkg::COUNT_PORT_BITS-1:0] day_count,
   input  logic [dasd_pkg::YEAR_BITS-1:0]       base_year,
   output logic                                 rsp_valid,
   output dasd_pkg::rsp_type                    rsp
);
   import dasd_pkg::*;

   localparam logic [COUNT_PORT_BITS-1:0] CNT_MASK = (COUNT_BITS >= COUNT_PORT_BITS) ?
      {COUNT_PORT_BITS{1'b1}} : COUNT_PORT_BITS'((32'd1 << COUNT_BITS) - 32'd1);
   localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

   state_type state_ff, state_in;

   logic                           func_ff, func_in;
   logic [YEAR_W-1:0]              y_ff, y_in;
   logic [MONTH_BITS-1:0]          m_ff, m_in;
   logic signed [DAY_ACC_BITS-1:0] dd_ff, dd_in;
   logic [COUNT_PORT_BITS-1:0]     cnt_ff, cnt_in;
   logic [MOD_BITS-1:0]            yr_ff, yr_in;
   logic                           valid_ff, valid_in;
   logic                           rerr_ff, rerr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;

   logic                           mod_start, mod_done;
   logic [MOD_BITS-1:0]            mod_rem;

   logic                           leap_cur, prev_leap;
   logic [DAY_BITS-1:0]            len_cur, prev_len, d_cur;
   logic [MOD_BITS-1:0]            yr_inc, yr_dec, prev_yr;
   logic [MONTH_BITS-1:0]          prev_m;
   logic [YEAR_W-1:0]              base_ext;
   logic signed [DAY_ACC_BITS-1:0] cnt_ext;
   logic                           add_more, sub_more, ovf_hit, unf_hit, date_ok;

   dasd_mod400 #(
      .YEAR_W(YEAR_W)
   ) u_mod400 (
      .clock(clock),
      .reset(reset),
      .start(mod_start),
      .year (YEAR_W'(year)),
      .done (mod_done),
      .rem  (mod_rem)
   );

   always_comb begin
      leap_cur  = is_leap(yr_ff);
      len_cur   = days_in_month(m_ff, leap_cur);
      d_cur     = dd_ff[DAY_BITS-1:0];
      yr_inc    = (yr_ff == CYCLE_LAST) ? '0 : yr_ff + MOD_BITS'(1);
      yr_dec    = (yr_ff == '0) ? CYCLE_LAST : yr_ff - MOD_BITS'(1);
      prev_m    = (m_ff == MONTH_JAN) ? MONTH_DEC : m_ff - MONTH_BITS'(1);
      prev_yr   = (m_ff == MONTH_JAN) ? yr_dec : yr_ff;
      prev_leap = is_leap(prev_yr);
      prev_len  = days_in_month(prev_m, prev_leap);
      base_ext  = YEAR_W'(base_year);
      cnt_ext   = $signed(DAY_ACC_BITS'(cnt_ff));
      add_more  = dd_ff > $signed(DAY_ACC_BITS'(len_cur));
      sub_more  = dd_ff < $signed(DAY_ACC_BITS'(1));
      ovf_hit   = add_more && (m_ff == MONTH_DEC) && (y_ff >= MAX_Y);
      unf_hit   = sub_more && (m_ff == MONTH_JAN) && (y_ff <= base_ext);
      date_ok   = (y_ff >= base_ext) && (y_ff <= MAX_Y) && (m_ff >= MONTH_JAN) &&
                  (m_ff <= MONTH_DEC) && (d_cur != '0) && (d_cur <= len_cur);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_MOD;
         ST_MOD:   if (mod_done) state_in = ST_CHECK;
         ST_CHECK: state_in = date_ok ? ST_STEP : ST_DONE;
         ST_STEP: begin
            if (func_ff ? (!sub_more || unf_hit) : (!add_more || ovf_hit)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mod_start    = (state_ff == ST_IDLE) && start;
      busy         = (state_ff != ST_IDLE);
      rsp_valid_in = (state_ff == ST_DONE);
   end

   always_comb begin
      func_in  = func_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      dd_in    = dd_ff;
      cnt_in   = cnt_ff;
      yr_in    = yr_ff;
      valid_in = valid_ff;
      rerr_in  = rerr_ff;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = func;
               y_in    = YEAR_W'(year);
               m_in    = month;
               dd_in   = $signed(DAY_ACC_BITS'(day));
               cnt_in  = day_count & CNT_MASK;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               yr_in = mod_rem;
            end
         end
         ST_CHECK: begin
            valid_in = date_ok;
            rerr_in  = 1'b0;
            if (date_ok) begin
               dd_in = func_ff ? dd_ff - cnt_ext : dd_ff + cnt_ext;
            end
         end
         ST_STEP: begin
            if (!func_ff) begin
               if (ovf_hit) begin
                  rerr_in = 1'b1;
                  y_in    = MAX_Y;
                  m_in    = MONTH_DEC;
                  dd_in   = $signed(DAY_ACC_BITS'(DEC_DAYS));
               end else if (add_more) begin
                  dd_in = dd_ff - $signed(DAY_ACC_BITS'(len_cur));
                  if (m_ff == MONTH_DEC) begin
                     m_in  = MONTH_JAN;
                     y_in  = y_ff + YEAR_W'(1);
                     yr_in = yr_inc;
                  end else begin
                     m_in = m_ff + MONTH_BITS'(1);
                  end
               end
            end else begin
               if (unf_hit) begin
                  rerr_in = 1'b1;
                  y_in    = base_ext;
                  m_in    = MONTH_JAN;
                  dd_in   = $signed(DAY_ACC_BITS'(FIRST_DAY));
               end else if (sub_more) begin
                  m_in  = prev_m;
                  y_in  = (m_ff == MONTH_JAN) ? y_ff - YEAR_W'(1) : y_ff;
                  yr_in = prev_yr;
                  dd_in = dd_ff + $signed(DAY_ACC_BITS'(prev_len));
               end
            end
         end
         ST_DONE: begin
            rsp_in.year        = y_ff[YEAR_BITS-1:0];
            rsp_in.month       = m_ff;
            rsp_in.day         = d_cur;
            rsp_in.day_of_year = valid_ff ?
               DOY_BITS'(d_cur) + days_before(m_ff, leap_cur) : '0;
            rsp_in.input_valid = valid_ff;
            rsp_in.range_error = rerr_ff;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff  <= func_in;
      y_ff     <= y_in;
      m_ff     <= m_in;
      dd_ff    <= dd_in;
      cnt_ff   <= cnt_in;
      yr_ff    <= yr_in;
      valid_ff <= valid_in;
      rerr_ff  <= rerr_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

   a_step_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ((m_ff >= MONTH_JAN) && (m_ff <= MONTH_DEC)))
      else $error("month left its range while stepping");

   a_step_year: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (y_ff <= MAX_Y))
      else $error("year passed the upper limit while stepping");

   a_rerr_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.range_error) |-> rsp_ff.input_valid)
      else $error("range error flagged on an invalid input date");

   a_valid_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.input_valid) |->
         ((rsp_ff.day != '0) && (rsp_ff.day_of_year != '0)))
      else $error("valid result carries a zero day");

endmodule
